[rtl/ethernet_rx_frame_statistics_defines.svh]
// assertion macros used by the checker file
`ifndef ETHERNET_RX_FRAME_STATISTICS_DEFINES_SVH
`define ETHERNET_RX_FRAME_STATISTICS_DEFINES_SVH

// same-cycle implication
`define ERFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ERFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/erfs_pkg.sv]
`default_nettype none
package erfs_pkg;

   // number of receive ports
   localparam int NUM_PORTS = 4;

   // counters per port
   localparam int NUM_CNT = 14;

   // item opcodes
   localparam logic [0:0] OP_COUNT = 1'b0;
   localparam logic [0:0] OP_READ  = 1'b1;

   // counter selector codes
   localparam logic [3:0] CNT_ARP    = 4'd0;
   localparam logic [3:0] CNT_IPV4   = 4'd1;
   localparam logic [3:0] CNT_IPV6   = 4'd2;
   localparam logic [3:0] CNT_VLAN   = 4'd3;
   localparam logic [3:0] CNT_SZ64   = 4'd4;
   localparam logic [3:0] CNT_SZ65   = 4'd5;
   localparam logic [3:0] CNT_SZ128  = 4'd6;
   localparam logic [3:0] CNT_SZ256  = 4'd7;
   localparam logic [3:0] CNT_SZ512  = 4'd8;
   localparam logic [3:0] CNT_SZ1024 = 4'd9;
   localparam logic [3:0] CNT_RUNT   = 4'd10;
   localparam logic [3:0] CNT_JUMBO  = 4'd11;
   localparam logic [3:0] CNT_BCAST  = 4'd12;
   localparam logic [3:0] CNT_MCAST  = 4'd13;

   // recognized ethertypes
   localparam logic [15:0] ETH_ARP  = 16'h0806;
   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;
   localparam logic [15:0] ETH_VLAN = 16'h8100;

   // frame size limits, CRC included, and the group address bit
   localparam logic [14:0] CRC_BYTES = 15'd4;
   localparam logic [14:0] MIN_FRAME = 15'd64;
   localparam logic [14:0] MAX_FRAME = 15'd1518;
   localparam int          GROUP_BIT = 40;

   // counter groups, each with its own memory
   localparam int NUM_GRP  = 3;
   localparam int GRP_TYPE = 0;
   localparam int GRP_SIZE = 1;
   localparam int GRP_CAST = 2;

   // counters in a group
   function automatic int grp_len(input int grp);
      int len;
      case (grp)
         GRP_TYPE: len = 4;
         GRP_SIZE: len = 8;
         default:  len = 2;
      endcase
      return len;
   endfunction

   // address width wide enough for every group
   localparam int ADDR_W = $clog2(NUM_PORTS * 8);

   // counter width
   localparam int CNT_W = 64;

endpackage
`default_nettype wire

[rtl/erfs_cnt_ram.sv]
`default_nettype none
module erfs_cnt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]             wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [WIDTH-1:0]             rd_data,
   output logic                              rd_valid
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule
`default_nettype wire

[rtl/ethernet_rx_frame_statistics.sv]
// a read result passes through the stage 1, stage 2 and result registers once accepted
// one item per cycle unless req_stall, set by one read-modify-write port per group
// back-to-back updates of one counter are forwarded from the write stage
// reset: clears the pipeline and every entry valid bit, so all counters read zero
// there is no clearing pass and items are accepted right after reset
`default_nettype none
module ethernet_rx_frame_statistics (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [0:0]  req_op,
   input  wire logic [1:0]  req_port,
   input  wire logic [13:0] req_frame_len,
   input  wire logic [15:0] req_eth_type,
   input  wire logic [47:0] req_dest_mac,
   input  wire logic [3:0]  req_counter_sel,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_counter_value
);

   localparam int NG = erfs_pkg::NUM_GRP;
   localparam int AW = erfs_pkg::ADDR_W;
   localparam int CW = erfs_pkg::CNT_W;

   // decode of the incoming item
   logic          port_ok;
   logic [14:0]   plen;
   logic [3:0]    size_code;
   logic [NG-1:0] en_in;
   logic [2:0]    sub_in [NG];
   logic [AW-1:0] addr_in [NG];
   logic          ok_in;
   logic [1:0]    grp_in;

   // stage 1
   logic          s1_vld_ff;
   logic          s1_read_ff;
   logic          s1_ok_ff;
   logic [1:0]    s1_grp_ff;
   logic [NG-1:0] s1_en_ff;
   logic [AW-1:0] s1_addr_ff [NG];

   // stage 2
   logic          s2_vld_ff;
   logic          s2_read_ff;
   logic          s2_ok_ff;
   logic [1:0]    s2_grp_ff;
   logic [NG-1:0] s2_en_ff;
   logic [AW-1:0] s2_addr_ff [NG];
   logic [NG-1:0] s2_fwd_ff;
   logic [CW-1:0] s2_fwdv_ff [NG];
   logic [NG-1:0] fwd_in;

   // counter datapath
   logic [CW-1:0] rd_data [NG];
   logic [NG-1:0] rd_valid;
   logic [CW-1:0] cur [NG];
   logic [CW-1:0] nxt [NG];
   logic [NG-1:0] we;
   logic [CW-1:0] value_in;

   logic rsp_valid_ff;
   logic [CW-1:0] rsp_value_ff;
   logic hold;
   logic advance;

   // pipeline stops only when a read result cannot enter a full output
   assign hold      = s2_vld_ff && s2_read_ff && rsp_valid_ff && rsp_stall;
   assign advance   = !hold;
   assign req_stall = hold;

   // item decode
   always_comb begin
      port_ok = int'(req_port) < erfs_pkg::NUM_PORTS;
      plen    = 15'(req_frame_len) + erfs_pkg::CRC_BYTES;

      // size bin
      if (plen == erfs_pkg::MIN_FRAME) begin
         size_code = erfs_pkg::CNT_SZ64;
      end else if (plen < erfs_pkg::MIN_FRAME) begin
         size_code = erfs_pkg::CNT_RUNT;
      end else if (plen <= 15'd127) begin
         size_code = erfs_pkg::CNT_SZ65;
      end else if (plen <= 15'd255) begin
         size_code = erfs_pkg::CNT_SZ128;
      end else if (plen <= 15'd511) begin
         size_code = erfs_pkg::CNT_SZ256;
      end else if (plen <= 15'd1023) begin
         size_code = erfs_pkg::CNT_SZ512;
      end else if (plen <= erfs_pkg::MAX_FRAME) begin
         size_code = erfs_pkg::CNT_SZ1024;
      end else begin
         size_code = erfs_pkg::CNT_JUMBO;
      end

      ok_in = port_ok && (req_counter_sel < 4'(erfs_pkg::NUM_CNT));
      if (req_counter_sel < erfs_pkg::CNT_SZ64) begin
         grp_in = 2'(erfs_pkg::GRP_TYPE);
      end else if (req_counter_sel < erfs_pkg::CNT_BCAST) begin
         grp_in = 2'(erfs_pkg::GRP_SIZE);
      end else begin
         grp_in = 2'(erfs_pkg::GRP_CAST);
      end

      en_in = '0;
      if (req_op == erfs_pkg::OP_READ) begin
         // read: a sub index is derived for every group, only the selected one is used
         sub_in[erfs_pkg::GRP_TYPE] = {1'b0, req_counter_sel[1:0]};
         sub_in[erfs_pkg::GRP_SIZE] = 3'(req_counter_sel - erfs_pkg::CNT_SZ64);
         sub_in[erfs_pkg::GRP_CAST] = 3'(req_counter_sel - erfs_pkg::CNT_BCAST) & 3'd1;
      end else begin
         // ethertype group
         case (req_eth_type)
            erfs_pkg::ETH_ARP: begin
               sub_in[erfs_pkg::GRP_TYPE] = 3'(erfs_pkg::CNT_ARP);
               en_in[erfs_pkg::GRP_TYPE]  = port_ok;
            end
            erfs_pkg::ETH_IPV4: begin
               sub_in[erfs_pkg::GRP_TYPE] = 3'(erfs_pkg::CNT_IPV4);
               en_in[erfs_pkg::GRP_TYPE]  = port_ok;
            end
            erfs_pkg::ETH_IPV6: begin
               sub_in[erfs_pkg::GRP_TYPE] = 3'(erfs_pkg::CNT_IPV6);
               en_in[erfs_pkg::GRP_TYPE]  = port_ok;
            end
            erfs_pkg::ETH_VLAN: begin
               sub_in[erfs_pkg::GRP_TYPE] = 3'(erfs_pkg::CNT_VLAN);
               en_in[erfs_pkg::GRP_TYPE]  = port_ok;
            end
            default: begin
               sub_in[erfs_pkg::GRP_TYPE] = 3'(erfs_pkg::CNT_ARP);
            end
         endcase
         // size group, bumped for every frame on a valid port
         sub_in[erfs_pkg::GRP_SIZE] = 3'(size_code - erfs_pkg::CNT_SZ64);
         en_in[erfs_pkg::GRP_SIZE]  = port_ok;
         // broadcast wins over multicast
         if (req_dest_mac == {48{1'b1}}) begin
            sub_in[erfs_pkg::GRP_CAST] = 3'(erfs_pkg::CNT_BCAST - erfs_pkg::CNT_BCAST);
            en_in[erfs_pkg::GRP_CAST]  = port_ok;
         end else begin
            sub_in[erfs_pkg::GRP_CAST] = 3'(erfs_pkg::CNT_MCAST - erfs_pkg::CNT_BCAST);
            en_in[erfs_pkg::GRP_CAST]  = port_ok && req_dest_mac[erfs_pkg::GROUP_BIT];
         end
      end

      // flat address per group memory
      for (int g = 0; g < NG; g++) begin
         addr_in[g] = AW'(int'(req_port) * erfs_pkg::grp_len(g) + int'(sub_in[g]));
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
      if (advance) begin
         s1_read_ff <= (req_op == erfs_pkg::OP_READ);
         s1_ok_ff   <= ok_in;
         s1_grp_ff  <= grp_in;
         s1_en_ff   <= en_in;
         s1_addr_ff <= addr_in;
      end
   end

   // counter memories, one per group
   for (genvar g = 0; g < NG; g++) begin : g_grp
      localparam int DEPTH_G = erfs_pkg::NUM_PORTS * erfs_pkg::grp_len(g);
      localparam int AW_G    = $clog2(DEPTH_G);

      erfs_cnt_ram #(
         .DEPTH (DEPTH_G),
         .WIDTH (CW)
      ) u_ram (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (we[g]),
         .wr_addr  (s2_addr_ff[g][AW_G-1:0]),
         .wr_data  (nxt[g]),
         .rd_en    (advance),
         .rd_addr  (s1_addr_ff[g][AW_G-1:0]),
         .rd_data  (rd_data[g]),
         .rd_valid (rd_valid[g])
      );
   end

   // read-modify-write with forwarding from the write stage
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         if (s2_fwd_ff[g]) begin
            cur[g] = s2_fwdv_ff[g];
         end else if (rd_valid[g]) begin
            cur[g] = rd_data[g];
         end else begin
            cur[g] = '0;
         end
         nxt[g]    = cur[g] + CW'(1);
         we[g]     = s2_vld_ff && s2_en_ff[g];
         fwd_in[g] = we[g] && (s2_addr_ff[g] == s1_addr_ff[g]);
      end
   end

   // selected counter for a read item
   always_comb begin
      value_in = '0;
      if (s2_ok_ff) begin
         case (s2_grp_ff)
            2'(erfs_pkg::GRP_TYPE): value_in = cur[erfs_pkg::GRP_TYPE];
            2'(erfs_pkg::GRP_SIZE): value_in = cur[erfs_pkg::GRP_SIZE];
            2'(erfs_pkg::GRP_CAST): value_in = cur[erfs_pkg::GRP_CAST];
            default:                value_in = '0;
         endcase
      end
   end

   // stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s2_read_ff <= s1_read_ff;
         s2_ok_ff   <= s1_ok_ff;
         s2_grp_ff  <= s1_grp_ff;
         s2_en_ff   <= s1_en_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_fwd_ff  <= fwd_in;
         s2_fwdv_ff <= nxt;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= s2_vld_ff && s2_read_ff;
      end
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_value_ff <= value_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_value = rsp_value_ff;

endmodule
`default_nettype wire

[rtl/erfs_checker.sv]
`default_nettype none
`include "ethernet_rx_frame_statistics_defines.svh"
module erfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_counter_value
);

   // no result straight after reset
   `ERFS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

   // input stalls only behind a stalled result
   `ERFS_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a stalled result holds
   `ERFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_counter_value))

   // an active input side never sees a stall without a waiting result
   `ERFS_ASSERT_IMPL(a_idle_no_stall, clock, reset, !rsp_valid && req_valid, !req_stall)

endmodule

bind ethernet_rx_frame_statistics erfs_checker u_erfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_counter_value (rsp_counter_value)
);
`default_nettype wire
